### rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the segment tree range sum block.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int LEAVES     = 1024;
	localparam int POS_W      = 11;
	localparam int VAL_W      = 64;
	localparam int NODE_COUNT = 2 * LEAVES;
	localparam int ADDR_W     = $clog2(NODE_COUNT);
	localparam int NODE_W     = ADDR_W + 1;
	localparam int TDATA_W    = ((2 * POS_W + VAL_W + 7) / 8) * 8;

	typedef enum logic {
		CMD_SET   = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SET_LEAF,
		ST_SET_DIFF,
		ST_SET_UP,
		ST_Q_SETUP,
		ST_Q_LO,
		ST_Q_HI
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] sum;
	} res_t;

endpackage

### rtl/sts_ram.sv
// ----------------------------------------------------------------------------
// sts_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/sts_walker.sv
// ----------------------------------------------------------------------------
// sts_walker
// Sequencer that clears the tree, walks leaf-to-root on a set and walks the
// range bottom-up on a query, reading and writing the node memory.
// ----------------------------------------------------------------------------
module sts_walker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  sts_pkg::cmd_t                in_cmd,
	input  logic [sts_pkg::POS_W-1:0]    in_first,
	input  logic [sts_pkg::POS_W-1:0]    in_last,
	input  logic [sts_pkg::VAL_W-1:0]    in_value,
	output sts_pkg::res_t                res,
	input  logic                         res_free,
	output logic                         rd_en,
	output logic [sts_pkg::ADDR_W-1:0]   rd_addr,
	input  logic [sts_pkg::VAL_W-1:0]    rd_data,
	output logic                         wr_en,
	output logic [sts_pkg::ADDR_W-1:0]   wr_addr,
	output logic [sts_pkg::VAL_W-1:0]    wr_data
);

	sts_pkg::state_t                state_q, state_d;
	logic [sts_pkg::ADDR_W-1:0]     clr_q, clr_d;
	logic [sts_pkg::POS_W-1:0]      first_q, last_q;
	logic [sts_pkg::VAL_W-1:0]      value_q;
	logic [sts_pkg::NODE_W-1:0]     lo_q, lo_d, hi_q, hi_d;
	logic [sts_pkg::VAL_W-1:0]      acc_q, acc_d, diff_q, diff_d, acc_sum;
	logic                           pend_q, pend_d;
	logic [31:0]                    f32, l32, fc, lc;
	logic [sts_pkg::NODE_W-1:0]     up_node, hi_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sts_pkg::ST_CLEAR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			first_q <= in_first;
			last_q  <= in_last;
			value_q <= in_value;
		end
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		acc_q  <= acc_d;
		diff_q <= diff_d;
	end

	assign f32     = 32'(first_q);
	assign l32     = 32'(last_q);
	assign fc      = (f32 == 32'd0) ? 32'd1 : f32;
	assign lc      = (l32 > 32'(sts_pkg::LEAVES)) ? 32'(sts_pkg::LEAVES) : l32;
	assign up_node = lo_q >> 1;
	assign hi_dec  = hi_q - sts_pkg::NODE_W'(1);
	assign acc_sum = acc_q + (pend_q ? rd_data : '0);
	assign in_ready = (state_q == sts_pkg::ST_IDLE);

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		acc_d     = acc_q;
		diff_d    = diff_q;
		pend_d    = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = lo_q[sts_pkg::ADDR_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = lo_q[sts_pkg::ADDR_W-1:0];
		wr_data   = '0;
		res.valid = 1'b0;
		res.sum   = acc_sum;
		unique case (state_q)
			sts_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				clr_d   = clr_q + sts_pkg::ADDR_W'(1);
				if (clr_q == sts_pkg::ADDR_W'(sts_pkg::NODE_COUNT - 1)) begin
					state_d = sts_pkg::ST_IDLE;
				end
			end
			sts_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_cmd == sts_pkg::CMD_SET) ? sts_pkg::ST_SET_LEAF
						: sts_pkg::ST_Q_SETUP;
				end
			end
			sts_pkg::ST_SET_LEAF: begin
				if (f32 == 32'd0 || f32 > 32'(sts_pkg::LEAVES)) begin
					state_d = sts_pkg::ST_IDLE;
				end else begin
					lo_d    = sts_pkg::NODE_W'(32'(sts_pkg::LEAVES) + f32 - 32'd1);
					rd_en   = 1'b1;
					rd_addr = lo_d[sts_pkg::ADDR_W-1:0];
					state_d = sts_pkg::ST_SET_DIFF;
				end
			end
			sts_pkg::ST_SET_DIFF, sts_pkg::ST_SET_UP: begin
				wr_en = 1'b1;
				if (state_q == sts_pkg::ST_SET_DIFF) begin
					wr_data = value_q;
					diff_d  = value_q - rd_data;
				end else begin
					wr_data = rd_data + diff_q;
				end
				lo_d = up_node;
				if (up_node == '0) begin
					state_d = sts_pkg::ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = up_node[sts_pkg::ADDR_W-1:0];
					state_d = sts_pkg::ST_SET_UP;
				end
			end
			sts_pkg::ST_Q_SETUP: begin
				acc_d = '0;
				if (f32 > l32 || fc > lc) begin
					lo_d = sts_pkg::NODE_W'(1);
					hi_d = '0;
				end else begin
					lo_d = sts_pkg::NODE_W'(32'(sts_pkg::LEAVES) + fc - 32'd1);
					hi_d = sts_pkg::NODE_W'(32'(sts_pkg::LEAVES) + lc - 32'd1);
				end
				state_d = sts_pkg::ST_Q_LO;
			end
			sts_pkg::ST_Q_LO: begin
				acc_d = acc_sum;
				if (lo_q <= hi_q && lo_q != '0) begin
					if (lo_q[0]) begin
						rd_en   = 1'b1;
						rd_addr = lo_q[sts_pkg::ADDR_W-1:0];
						pend_d  = 1'b1;
						lo_d    = lo_q + sts_pkg::NODE_W'(1);
					end
					state_d = sts_pkg::ST_Q_HI;
				end else if (res_free) begin
					res.valid = 1'b1;
					state_d   = sts_pkg::ST_IDLE;
				end
			end
			sts_pkg::ST_Q_HI: begin
				acc_d = acc_sum;
				lo_d  = lo_q >> 1;
				if (!hi_q[0]) begin
					rd_en   = 1'b1;
					rd_addr = hi_q[sts_pkg::ADDR_W-1:0];
					pend_d  = 1'b1;
					hi_d    = hi_dec >> 1;
				end else begin
					hi_d = hi_q >> 1;
				end
				state_d = sts_pkg::ST_Q_LO;
			end
			default: begin
				state_d = sts_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/segment_tree_range_sum.sv
// ----------------------------------------------------------------------------
// segment_tree_range_sum
// A set beat reads its leaf, then does one read-modify-write per tree level
// on the node memory before the next beat is taken. A query beat walks its
// range over the 1024 positions, at most two memory reads per level; its sum
// goes to the output register when the walk ends and waits there, stalling
// the walk while it is not taken.
// After reset the node memory is cleared at one entry a cycle, all 2048
// entries, and no input beat is taken until the clear is done.
// ----------------------------------------------------------------------------
module segment_tree_range_sum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// first_position [10:0], last_position [21:11], new_value [85:22], zero pad
	input  logic [sts_pkg::TDATA_W-1:0]   s_axis_tdata,
	// command [0]
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// range_sum [63:0]
	output logic [sts_pkg::VAL_W-1:0]     m_axis_tdata
);

	sts_pkg::res_t                res;
	logic                         res_free;
	logic                         rd_en, wr_en;
	logic [sts_pkg::ADDR_W-1:0]   rd_addr, wr_addr;
	logic [sts_pkg::VAL_W-1:0]    rd_data, wr_data;
	logic                         out_valid_q;
	logic [sts_pkg::VAL_W-1:0]    out_data_q;

	sts_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (sts_pkg::cmd_t'(s_axis_tuser)),
		.in_first (s_axis_tdata[sts_pkg::POS_W-1:0]),
		.in_last  (s_axis_tdata[2*sts_pkg::POS_W-1:sts_pkg::POS_W]),
		.in_value (s_axis_tdata[2*sts_pkg::POS_W+sts_pkg::VAL_W-1:2*sts_pkg::POS_W]),
		.res      (res),
		.res_free (res_free),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	sts_ram #(
		.WIDTH (sts_pkg::VAL_W),
		.DEPTH (sts_pkg::NODE_COUNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign res_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_data_q <= res.sum;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (!out_valid_q || m_axis_tready))
		else $error("result beat would overwrite a waiting result");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !s_axis_tready)
		else $error("result produced while the block is idle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input beat taken while the previous one is in work");

endmodule

### sim/segment_tree_range_sum_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_tree_range_sum_checker
// Watches both streams of the segment tree block and keeps its own copy of
// every position's value. Each query beat queues the sum of its clipped
// range, and each result beat is compared with the oldest queued sum.
// ----------------------------------------------------------------------------
module segment_tree_range_sum_checker
	import sts_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	input  logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,
	input  logic               s_axis_tuser,
	input  logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  logic [VAL_W-1:0]   m_axis_tdata,
	output int                 fail_count,
	output int                 sums_awaited
);

	logic [VAL_W-1:0] position_values [1:LEAVES];
	logic [VAL_W-1:0] expected_sums [$];
	int failures = 0;

	function automatic logic [VAL_W-1:0] clipped_range_sum(input logic [POS_W-1:0] first,
			input logic [POS_W-1:0] last);
		int lo;
		int hi;
		logic [VAL_W-1:0] total;
		total = '0;
		lo = (first < 1) ? 1 : int'(first);
		hi = (last > LEAVES) ? LEAVES : int'(last);
		if (first <= last) begin
			for (int p = lo; p <= hi; p++)
				total += position_values[p];
		end
		return total;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		cmd_t command;
		logic [POS_W-1:0] first;
		logic [POS_W-1:0] last;
		logic [VAL_W-1:0] value;
		logic [VAL_W-1:0] expected;
		if (!arst_n) begin
			for (int p = 1; p <= LEAVES; p++)
				position_values[p] = '0;
			expected_sums.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_sums.size() == 0) begin
					$display("%0t: range_sum %0d arrived with no query outstanding",
						$time, $signed(m_axis_tdata));
					failures++;
				end else begin
					expected = expected_sums.pop_front();
					if (m_axis_tdata !== expected) begin
						$display("%0t: range_sum mismatch, expected %0d, got %0d",
							$time, $signed(expected), $signed(m_axis_tdata));
						failures++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				command = cmd_t'(s_axis_tuser);
				first = s_axis_tdata[POS_W-1:0];
				last = s_axis_tdata[2*POS_W-1:POS_W];
				value = s_axis_tdata[2*POS_W +: VAL_W];
				if (command == CMD_QUERY) begin
					expected_sums.push_back(clipped_range_sum(first, last));
				end else if (first >= 1 && first <= LEAVES) begin
					position_values[first] = value;
				end
			end
		end
		fail_count <= failures;
		sums_awaited <= expected_sums.size();
	end

endmodule

### sim/segment_tree_range_sum_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_tree_range_sum_tb
// Drives set and query beats into the segment tree block: a directed opening
// on extreme values, wrapping sums, empty ranges and positions outside the
// tree, then random beats with random gaps on the input and random stalls
// on the output. The checker beside the block judges every range sum.
// ----------------------------------------------------------------------------
module segment_tree_range_sum_tb;
	import sts_pkg::*;

	localparam int IDLE_LIMIT = 10000;
	localparam int RANDOM_BEATS = 900;
	localparam logic [VAL_W-1:0] MAX_VALUE = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] MIN_VALUE = {1'b1, {(VAL_W-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [VAL_W-1:0] m_axis_tdata;
	int fail_count;
	int sums_awaited;
	int idle_cycles = 0;
	bit no_idling = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	segment_tree_range_sum dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	segment_tree_range_sum_checker sum_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.sums_awaited  (sums_awaited)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return MAX_VALUE;
			1: return MIN_VALUE;
			2: return {32'd0, 32'($urandom_range(0, 255))} - 64'd128;
			3: return {{(VAL_W-32){1'b1}}, 32'($urandom)};
			default: return {32'($urandom), 32'($urandom)};
		endcase
	endfunction

	task automatic send_beat(input cmd_t command, input logic [POS_W-1:0] first,
			input logic [POS_W-1:0] last, input logic [VAL_W-1:0] value);
		int gap;
		gap = no_idling ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= command;
		s_axis_tdata <= {{(TDATA_W-2*POS_W-VAL_W){1'b0}}, value, last, first};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	initial begin : result_sink
		int ready_run;
		int stall;
		@(posedge clk);
		forever begin
			ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
			m_axis_tready <= 1'b1;
			repeat (ready_run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int kind;
		int first_pos;
		int last_pos;
		int span;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(CMD_QUERY, 11'd1, 11'd1024, pick_value());
		send_beat(CMD_SET, 11'd1, POS_W'($urandom), MAX_VALUE);
		send_beat(CMD_SET, 11'd1024, POS_W'($urandom), MIN_VALUE);
		send_beat(CMD_SET, 11'd512, POS_W'($urandom), {VAL_W{1'b1}});
		send_beat(CMD_SET, 11'd513, POS_W'($urandom), 64'd1);
		send_beat(CMD_QUERY, 11'd1, 11'd1024, pick_value());
		send_beat(CMD_QUERY, 11'd1, 11'd1, pick_value());
		send_beat(CMD_QUERY, 11'd1024, 11'd1024, pick_value());
		send_beat(CMD_QUERY, 11'd512, 11'd513, pick_value());
		send_beat(CMD_SET, 11'd2, POS_W'($urandom), MAX_VALUE);
		send_beat(CMD_QUERY, 11'd1, 11'd2, pick_value());
		// Empty ranges, ranges wholly outside the tree and one that overhangs both ends.
		send_beat(CMD_QUERY, 11'd10, 11'd9, pick_value());
		send_beat(CMD_QUERY, 11'd2047, 11'd0, pick_value());
		send_beat(CMD_QUERY, 11'd0, 11'd0, pick_value());
		send_beat(CMD_QUERY, 11'd1025, 11'd2047, pick_value());
		send_beat(CMD_QUERY, 11'd0, 11'd2047, pick_value());
		// Sets outside the tree must leave every sum untouched.
		send_beat(CMD_SET, 11'd0, POS_W'($urandom), pick_value());
		send_beat(CMD_SET, 11'd1025, POS_W'($urandom), pick_value());
		send_beat(CMD_SET, 11'd2047, POS_W'($urandom), pick_value());
		send_beat(CMD_QUERY, 11'd0, 11'd2047, pick_value());
		send_beat(CMD_SET, 11'd1, POS_W'($urandom), 64'd0);
		send_beat(CMD_QUERY, 11'd1, 11'd3, pick_value());
		send_beat(CMD_QUERY, 11'd511, 11'd1024, pick_value());

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 150 == 0)
				no_idling = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			first_pos = $urandom_range(1, LEAVES);
			if (kind < 45) begin
				send_beat(CMD_SET, POS_W'(first_pos), POS_W'($urandom), pick_value());
			end else if (kind < 50) begin
				first_pos = $urandom_range(0, 1) ? 0
					: $urandom_range(LEAVES + 1, 2**POS_W - 1);
				send_beat(CMD_SET, POS_W'(first_pos), POS_W'($urandom), pick_value());
			end else if (kind < 88) begin
				case ($urandom_range(0, 2))
					0: span = $urandom_range(0, 15);
					1: span = $urandom_range(0, LEAVES - 1);
					default: begin
						first_pos = 1;
						span = LEAVES - 1;
					end
				endcase
				last_pos = first_pos + span;
				if (last_pos > 2**POS_W - 1)
					last_pos = 2**POS_W - 1;
				send_beat(CMD_QUERY, POS_W'(first_pos), POS_W'(last_pos),
					{32'($urandom), 32'($urandom)});
			end else begin
				send_beat(CMD_QUERY, POS_W'($urandom), POS_W'($urandom),
					{32'($urandom), 32'($urandom)});
			end
		end
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (sums_awaited != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && sums_awaited == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
